### rtl/core/uvs_pkg.sv
// Package with the widths, types and helper functions of the UV sphere index generator.
`timescale 1ns / 1ps

package uvs_pkg;

  localparam int MaxSlices = 256;
  localparam int MaxStacks = 256;
  localparam int MinSlices = 3;
  localparam int MinStacks = 2;

  localparam int IdxW     = 17;
  localparam int CntW     = 9;
  localparam int SegW     = 8;
  localparam int RingW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int InDataW  = 8;
  localparam int OutDataW = 56;
  localparam int OutPadW  = OutDataW - 3 * IdxW;

  localparam logic [CfgIdxW-1:0] REG_SLICE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STACK_COUNT = 2'd1;

  localparam logic [CntW-1:0] ResetSlices = 9'd16;
  localparam logic [CntW-1:0] ResetStacks = 9'd8;

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [1:0] {
    REGION_TOP,
    REGION_MIDDLE,
    REGION_BOTTOM
  } region_t;

  typedef struct packed {
    logic [CntW-1:0] slices;
    logic [CntW-1:0] stacks;
    idx_t            bottom;
  } geom_t;

  typedef struct packed {
    idx_t first;
    idx_t second;
    idx_t third;
    logic fin;
  } tri_t;

  function automatic logic [CntW-1:0] clamp_count(input logic [CfgDataW-1:0] v,
                                                  input logic [CntW-1:0] lo,
                                                  input logic [CntW-1:0] hi);
    logic [CntW-1:0] res;
    res = CntW'(v);
    if (res < lo) begin
      res = lo;
    end else if (res > hi) begin
      res = hi;
    end
    return res;
  endfunction

  function automatic idx_t bottom_index(input logic [CntW-1:0] slices,
                                        input logic [CntW-1:0] stacks);
    logic [CntW-1:0]   tm1;
    logic [CntW-1:0]   sp1;
    logic [2*CntW-1:0] prod;
    tm1  = stacks - CntW'(1);
    sp1  = slices + CntW'(1);
    prod = tm1 * sp1;
    return IdxW'(prod) + IdxW'(1);
  endfunction

endpackage

### rtl/core/uvs_cfg.sv
// Configuration registers with clamped slice and stack counts and the bottom pole index.
`timescale 1ns / 1ps

module uvs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [uvs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [uvs_pkg::CfgDataW-1:0] cfg_data,
  output uvs_pkg::geom_t               geom
);

  logic [uvs_pkg::CntW-1:0] slices_r, slices_nxt;
  logic [uvs_pkg::CntW-1:0] stacks_r, stacks_nxt;
  uvs_pkg::idx_t            bottom_r, bottom_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    slices_nxt = slices_r;
    stacks_nxt = stacks_r;
    if (cfg_valid) begin
      case (cfg_index)
        uvs_pkg::REG_SLICE_COUNT: begin
          slices_nxt = uvs_pkg::clamp_count(cfg_data, uvs_pkg::CntW'(uvs_pkg::MinSlices),
                                            uvs_pkg::CntW'(uvs_pkg::MaxSlices));
        end
        uvs_pkg::REG_STACK_COUNT: begin
          stacks_nxt = uvs_pkg::clamp_count(cfg_data, uvs_pkg::CntW'(uvs_pkg::MinStacks),
                                            uvs_pkg::CntW'(uvs_pkg::MaxStacks));
        end
        default: begin
        end
      endcase
    end
    bottom_nxt = uvs_pkg::bottom_index(slices_nxt, stacks_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r <= uvs_pkg::ResetSlices;
      stacks_r <= uvs_pkg::ResetStacks;
      bottom_r <= uvs_pkg::bottom_index(uvs_pkg::ResetSlices, uvs_pkg::ResetStacks);
    end else begin
      slices_r <= slices_nxt;
      stacks_r <= stacks_nxt;
      bottom_r <= bottom_nxt;
    end
  end

  assign geom.slices = slices_r;
  assign geom.stacks = stacks_r;
  assign geom.bottom = bottom_r;

endmodule

### rtl/core/uvs_tri_gen.sv
// Sequence state and triangle index arithmetic, advanced once per accepted transfer.
`timescale 1ns / 1ps

module uvs_tri_gen (
  input  logic           clk,
  input  logic           rst_n,
  input  uvs_pkg::geom_t geom,
  input  logic           step,
  input  logic           restart,
  output uvs_pkg::tri_t  tri_res
);

  uvs_pkg::region_t          region_r, region_nxt;
  logic [uvs_pkg::RingW-1:0] ring_r, ring_nxt;
  logic [uvs_pkg::SegW-1:0]  seg_r, seg_nxt;
  logic                      half_r, half_nxt;
  uvs_pkg::idx_t             base_r, base_nxt;

  uvs_pkg::region_t          region_e;
  logic [uvs_pkg::RingW-1:0] ring_e;
  logic [uvs_pkg::SegW-1:0]  seg_e;
  logic                      half_e;
  uvs_pkg::idx_t             base_e;

  logic [uvs_pkg::CntW-1:0]  seg_inc;
  logic [uvs_pkg::CntW-1:0]  ring_inc;
  logic [uvs_pkg::CntW-1:0]  ring_len;
  logic                      last_seg;
  uvs_pkg::idx_t             base_s, base_s1, upper, upper_s, upper_s1;

  always_comb begin
    if (restart) begin
      region_e = uvs_pkg::REGION_TOP;
      ring_e   = '0;
      seg_e    = '0;
      half_e   = 1'b0;
      base_e   = uvs_pkg::IdxW'(1);
    end else begin
      region_e = region_r;
      ring_e   = ring_r;
      seg_e    = seg_r;
      half_e   = half_r;
      base_e   = base_r;
    end

    seg_inc  = uvs_pkg::CntW'(seg_e) + uvs_pkg::CntW'(1);
    ring_inc = uvs_pkg::CntW'(ring_e) + uvs_pkg::CntW'(1);
    ring_len = geom.slices + uvs_pkg::CntW'(1);
    last_seg = (seg_inc >= geom.slices);
    base_s   = base_e + uvs_pkg::IdxW'(seg_e);
    base_s1  = base_s + uvs_pkg::IdxW'(1);
    upper    = base_e + uvs_pkg::IdxW'(ring_len);
    upper_s  = upper + uvs_pkg::IdxW'(seg_e);
    upper_s1 = upper_s + uvs_pkg::IdxW'(1);

    region_nxt = region_e;
    ring_nxt   = ring_e;
    seg_nxt    = seg_e;
    half_nxt   = half_e;
    base_nxt   = base_e;
    tri_res.fin = 1'b0;

    case (region_e)
      uvs_pkg::REGION_MIDDLE: begin
        tri_res.first = base_s;
        if (!half_e) begin
          tri_res.second = upper_s;
          tri_res.third  = upper_s1;
          half_nxt       = 1'b1;
        end else begin
          tri_res.second = upper_s1;
          tri_res.third  = base_s1;
          half_nxt       = 1'b0;
          if (last_seg) begin
            seg_nxt  = '0;
            ring_nxt = uvs_pkg::RingW'(ring_inc);
            base_nxt = upper;
            if (ring_inc >= geom.stacks - uvs_pkg::CntW'(uvs_pkg::MinStacks)) begin
              region_nxt = uvs_pkg::REGION_BOTTOM;
            end
          end else begin
            seg_nxt = uvs_pkg::SegW'(seg_inc);
          end
        end
      end
      uvs_pkg::REGION_BOTTOM: begin
        tri_res.first  = geom.bottom;
        tri_res.second = base_s1;
        tri_res.third  = base_s;
        if (last_seg) begin
          tri_res.fin = 1'b1;
          region_nxt  = uvs_pkg::REGION_TOP;
          ring_nxt    = '0;
          seg_nxt     = '0;
          half_nxt    = 1'b0;
          base_nxt    = uvs_pkg::IdxW'(1);
        end else begin
          seg_nxt = uvs_pkg::SegW'(seg_inc);
        end
      end
      default: begin
        tri_res.first  = '0;
        tri_res.second = base_s;
        tri_res.third  = base_s1;
        if (last_seg) begin
          seg_nxt  = '0;
          ring_nxt = '0;
          half_nxt = 1'b0;
          base_nxt = uvs_pkg::IdxW'(1);
          if (geom.stacks > uvs_pkg::CntW'(uvs_pkg::MinStacks)) begin
            region_nxt = uvs_pkg::REGION_MIDDLE;
          end else begin
            region_nxt = uvs_pkg::REGION_BOTTOM;
          end
        end else begin
          seg_nxt = uvs_pkg::SegW'(seg_inc);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= uvs_pkg::REGION_TOP;
      ring_r   <= '0;
      seg_r    <= '0;
      half_r   <= 1'b0;
      base_r   <= uvs_pkg::IdxW'(1);
    end else if (step) begin
      region_r <= region_nxt;
      ring_r   <= ring_nxt;
      seg_r    <= seg_nxt;
      half_r   <= half_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule

### rtl/core/uvs_skid.sv
// Result register with a skid register, so that input transfers continue while a result waits.
`timescale 1ns / 1ps

module uvs_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  uvs_pkg::tri_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  input  logic          pop_ready,
  output uvs_pkg::tri_t pop_data
);

  logic          main_valid_r, main_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  uvs_pkg::tri_t main_r, main_nxt;
  uvs_pkg::tri_t skid_r, skid_nxt;

  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop_ready) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### rtl/core/uv_sphere_index_generator.sv
// Top level of the UV sphere triangle index generator.
//
//   Channel  Direction  Signals                                  Content
//   in_      slave      in_tvalid in_tready in_tdata[7:0]         restart flag
//   out_     master     out_tvalid out_tready out_tdata[55:0]     three vertex indices
//                       out_tlast                                 final triangle of sphere
//   cfg_     slave      cfg_valid cfg_ready cfg_index cfg_data    slice and stack counts
//
// One triangle is accepted per clock unless the input stalls. Its result is registered
// in the result register or, on an output stall, in a skid register; the input then
// stalls until the result is taken. One chain of 17-bit additions from the sequence
// registers to the result register sets the cycle time. Reset is synchronous, returns
// the sequence to the first top-cap triangle and sets the counts to 16 and 8.
`timescale 1ns / 1ps

module uv_sphere_index_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [uvs_pkg::InDataW-1:0]   in_tdata,   // [0] restart, rest zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [uvs_pkg::OutDataW-1:0]  out_tdata,  // index_first, index_second, index_third
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [uvs_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [uvs_pkg::CfgDataW-1:0]  cfg_data
);

  uvs_pkg::geom_t geom;
  uvs_pkg::tri_t  tri_new;
  uvs_pkg::tri_t  tri_out;
  logic           in_xfer;

  assign in_xfer = in_tvalid && in_tready;

  uvs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  uvs_tri_gen u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .geom    (geom),
    .step    (in_xfer),
    .restart (in_tdata[0]),
    .tri_res (tri_new)
  );

  uvs_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_xfer),
    .push_data  (tri_new),
    .push_ready (in_tready),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_data   (tri_out)
  );

  assign out_tdata = {{uvs_pkg::OutPadW{1'b0}}, tri_out.third, tri_out.second, tri_out.first};
  assign out_tlast = tri_out.fin;

endmodule

### rtl/core/uvs_checker.sv
// Port-level assertions for the UV sphere index generator and their bind to the top level.
`timescale 1ns / 1ps

module uvs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [uvs_pkg::InDataW-1:0]   in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [uvs_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Stalled result changed or was withdrawn.");

  a_in_blocked_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("Input stalled with no result waiting.");

  a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[0] && !out_tvalid |=>
      out_tvalid && out_tdata[16:0] == 17'd0 && out_tdata[33:17] == 17'd1 &&
      out_tdata[50:34] == 17'd2 && !out_tlast)
    else $error("Restart transfer did not give the first top-cap triangle.");

  a_last_winding: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[33:17] == out_tdata[50:34] + 17'd1)
    else $error("Final triangle does not have reversed bottom-cap winding.");

  a_top_cap_winding: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16:0] == 17'd0 |-> out_tdata[50:34] == out_tdata[33:17] + 17'd1)
    else $error("Top-cap triangle has wrong winding.");

endmodule

bind uv_sphere_index_generator uvs_checker u_uvs_checker (.*);
